### hdl/wph_pkg.sv
// Shared constants, types and the arctangent table for the waypoint heading and distance unit.
`default_nettype none
package wph_pkg;

    localparam int GUARD_BITS = 8;
    localparam int FRAC_BITS  = 8;
    localparam int ANG_FRAC   = 16;
    localparam int Z_W        = 27;
    localparam int HEAD_W     = 9;
    localparam int DIST_W     = 17;
    localparam int GAIN_BITS  = 16;

    localparam logic [GAIN_BITS-1:0] GAIN_Q16 = 16'd39797;
    localparam logic [DIST_W-1:0]    DIST_MAX = 17'd131071;
    localparam logic [10:0]          HEAD_MAX = 11'd180;
    localparam logic signed [Z_W-1:0] Z_HALF_TURN = 27'sd11796480;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_PREP   = 5'b00010,
        S_CORDIC = 5'b00100,
        S_MUL    = 5'b01000,
        S_WAIT   = 5'b10000
    } t_state;

    // atan(2^-i) in degrees with 16 fraction bits, rounded to nearest.
    function automatic logic [Z_W-1:0] atan_q16(input logic [4:0] i);
        logic [Z_W-1:0] v;
        case (i)
            5'd0:  v = 27'd2949120;
            5'd1:  v = 27'd1740967;
            5'd2:  v = 27'd919879;
            5'd3:  v = 27'd466945;
            5'd4:  v = 27'd234379;
            5'd5:  v = 27'd117304;
            5'd6:  v = 27'd58666;
            5'd7:  v = 27'd29335;
            5'd8:  v = 27'd14668;
            5'd9:  v = 27'd7334;
            5'd10: v = 27'd3667;
            5'd11: v = 27'd1833;
            5'd12: v = 27'd917;
            5'd13: v = 27'd458;
            5'd14: v = 27'd229;
            5'd15: v = 27'd115;
            5'd16: v = 27'd57;
            5'd17: v = 27'd29;
            5'd18: v = 27'd14;
            5'd19: v = 27'd7;
            5'd20: v = 27'd4;
            5'd21: v = 27'd2;
            5'd22: v = 27'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

### hdl/wph_cordic.sv
// Iterative CORDIC in vectoring mode, one micro-rotation per cycle.
`default_nettype none
module wph_cordic
    import wph_pkg::*;
#(
    parameter int STEPS = 16,
    parameter int XW    = 35
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic signed [XW-1:0] i_x,
    input  wire logic signed [XW-1:0] i_y,
    input  wire logic signed [Z_W-1:0] i_z,
    output logic                      o_done,
    output logic signed [XW-1:0]      o_x,
    output logic signed [Z_W-1:0]     o_z
);

    localparam int SW = $clog2(STEPS);

    logic signed [XW-1:0]  r_x, r_y;
    logic signed [Z_W-1:0] r_z;
    logic [SW-1:0]         r_cnt;
    logic                  r_busy, r_done;
    logic signed [XW-1:0]  xs, ys;
    logic signed [Z_W-1:0] ang;

    assign xs  = r_x >>> r_cnt;
    assign ys  = r_y >>> r_cnt;
    assign ang = signed'(atan_q16(5'(r_cnt)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == SW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_x;
            r_y <= i_y;
            r_z <= i_z;
        end else if (r_busy) begin
            if (!r_y[XW-1]) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + ang;
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - ang;
            end
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_z    = r_z;

endmodule
`default_nettype wire

### hdl/wph_serial_mul.sv
// Shift-and-add multiplier by the CORDIC gain, one multiplier bit per cycle.
`default_nettype none
module wph_serial_mul
    import wph_pkg::*;
#(
    parameter int XW = 35
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [XW-1:0]            i_x,
    output logic                          o_done,
    output logic [XW+GAIN_BITS-1:0]       o_prod
);

    localparam int PW = XW + GAIN_BITS;

    logic [PW-1:0]        r_m, r_acc;
    logic [GAIN_BITS-1:0] r_g;
    logic [3:0]           r_cnt;
    logic                 r_busy, r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 4'(GAIN_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Multiplicand shifts left, gain shifts right; the low gain bit picks the add.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_m   <= PW'(i_x);
            r_g   <= GAIN_Q16;
            r_acc <= '0;
        end else if (r_busy) begin
            r_m <= r_m << 1;
            r_g <= r_g >> 1;
            if (r_g[0]) begin
                r_acc <= r_acc + r_m;
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule
`default_nettype wire

### hdl/waypoint_heading_distance_unit.sv
// Top level of the waypoint heading and distance unit.
//
//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+-------------------------------
//  target  | in        | i_in_valid / o_in_ready      | i_target_x, i_target_y
//  result  | out       | o_out_valid / i_out_ready    | o_heading_deg, o_travel_dist
//
// A word that needs the CORDIC passes through the iterative CORDIC rotator and then
// the bit-serial gain multiplier before its result reaches the output register.
// Words on an axis or with zero delta skip both. Reset clears the stored position
// to zero and empties the output register. A stalled output holds its word while
// the next target is taken.
`default_nettype none
module waypoint_heading_distance_unit
    import wph_pkg::*;
#(
    parameter int CORDIC_STEPS = 16,
    parameter int COORD_WIDTH  = 24
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic signed [23:0]        i_target_x,
    input  wire logic signed [23:0]        i_target_y,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic signed [HEAD_W-1:0]       o_heading_deg,
    output logic [DIST_W-1:0]              o_travel_dist
);

    localparam int CW = COORD_WIDTH;
    localparam int DW = CW + 1;       // delta width
    localparam int XW = CW + 11;      // delta, guard bits and CORDIC growth
    localparam int PW = XW + GAIN_BITS;
    localparam int QW = PW - (GAIN_BITS + FRAC_BITS + GUARD_BITS);

    t_state r_state, n_state;

    logic signed [CW-1:0] r_pos_x, r_pos_y;
    logic signed [DW-1:0] r_dx, r_dy;
    logic signed [HEAD_W-1:0] r_head;
    logic [DIST_W-1:0]    r_dist;
    logic signed [HEAD_W-1:0] r_out_head;
    logic [DIST_W-1:0]    r_out_dist;
    logic                 r_out_valid;

    logic                 in_acc, out_free;
    logic signed [CW-1:0] tx, ty;
    logic [DW-1:0]        abs_dx, abs_dy;
    logic [DW-9:0]        ax_int, ay_int;
    logic                 cordic_start, mul_start, cordic_done, mul_done;
    logic signed [XW-1:0] c_x0, c_y0, c_x;
    logic signed [Z_W-1:0] c_z0, c_z;
    logic [XW-1:0]        x_pos;
    logic [PW-1:0]        prod;
    logic [QW-1:0]        q;
    logic [Z_W-1:0]       z_mag;
    logic [10:0]          h_mag;
    logic [HEAD_W-1:0]    h_clamp;

    // Only the low COORD_WIDTH bits of each coordinate count.
    assign tx = signed'(CW'($unsigned(i_target_x)));
    assign ty = signed'(CW'($unsigned(i_target_y)));

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign out_free   = !r_out_valid || i_out_ready;

    assign abs_dx = r_dx[DW-1] ? DW'(-r_dx) : DW'(r_dx);
    assign abs_dy = r_dy[DW-1] ? DW'(-r_dy) : DW'(r_dy);
    assign ax_int = abs_dx[DW-1:FRAC_BITS];
    assign ay_int = abs_dy[DW-1:FRAC_BITS];

    // Left half plane: turn the vector by half a turn before the rotations.
    always_comb begin
        if (r_dx[DW-1]) begin
            c_x0 = -(XW'(r_dx) <<< GUARD_BITS);
            c_y0 = -(XW'(r_dy) <<< GUARD_BITS);
            c_z0 = r_dy[DW-1] ? -Z_HALF_TURN : Z_HALF_TURN;
        end else begin
            c_x0 = XW'(r_dx) <<< GUARD_BITS;
            c_y0 = XW'(r_dy) <<< GUARD_BITS;
            c_z0 = '0;
        end
    end

    assign cordic_start = (r_state == S_PREP) && (r_dx != '0) && (r_dy != '0);
    assign mul_start    = (r_state == S_CORDIC) && cordic_done;
    assign x_pos        = c_x[XW-1] ? '0 : XW'(c_x);

    wph_cordic #(
        .STEPS (CORDIC_STEPS),
        .XW    (XW)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_start),
        .i_x     (c_x0),
        .i_y     (c_y0),
        .i_z     (c_z0),
        .o_done  (cordic_done),
        .o_x     (c_x),
        .o_z     (c_z)
    );

    wph_serial_mul #(
        .XW (XW)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_x     (x_pos),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    // Heading truncates toward zero, then clamps to half a turn either way.
    assign q     = prod[PW-1:PW-QW];
    assign z_mag = c_z[Z_W-1] ? Z_W'(-c_z) : Z_W'(c_z);
    assign h_mag = z_mag[ANG_FRAC+10:ANG_FRAC];
    assign h_clamp = (h_mag > HEAD_MAX) ? HEAD_W'(HEAD_MAX) : HEAD_W'(h_mag);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (in_acc) n_state = S_PREP;
            S_PREP:   n_state = cordic_start ? S_CORDIC : S_WAIT;
            S_CORDIC: if (cordic_done) n_state = S_MUL;
            S_MUL:    if (mul_done) n_state = S_WAIT;
            S_WAIT:   if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_pos_x <= tx;
                r_pos_y <= ty;
            end
            if (r_state == S_WAIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_dx <= DW'(tx) - DW'(r_pos_x);
            r_dy <= DW'(ty) - DW'(r_pos_y);
        end
        if (r_state == S_PREP) begin
            if (r_dy == '0) begin
                r_head <= (r_dx[DW-1]) ? HEAD_W'(HEAD_MAX) : '0;
                r_dist <= (ax_int > DW'(DIST_MAX)) ? DIST_MAX : DIST_W'(ax_int);
            end else if (r_dx == '0) begin
                r_head <= r_dy[DW-1] ? -HEAD_W'(9'sd90) : HEAD_W'(9'sd90);
                r_dist <= (ay_int > DW'(DIST_MAX)) ? DIST_MAX : DIST_W'(ay_int);
            end
        end
        if (r_state == S_MUL && mul_done) begin
            r_head <= c_z[Z_W-1] ? -signed'(h_clamp) : signed'(h_clamp);
            r_dist <= (q > QW'(DIST_MAX)) && (QW >= DIST_W) ? DIST_MAX : DIST_W'(q);
        end
        if (r_state == S_WAIT && out_free) begin
            r_out_head <= r_head;
            r_out_dist <= r_dist;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_heading_deg = r_out_head;
    assign o_travel_dist = r_out_dist;

    a_accept_to_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_PREP))
        else $error("accepted word did not move on to preparation");

    a_pos_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_pos_x == $past(tx)) && (r_pos_y == $past(ty)))
        else $error("stored position not updated from the target");

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_heading_deg <= 9'sd180) && (o_heading_deg >= -9'sd180))
        else $error("heading outside half a turn");

    a_mul_after_cordic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == S_MUL))
        else $error("multiplier finished outside its state");

endmodule
`default_nettype wire
